[hdl/mmcm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmcm_pkg
// Shared types and constants for the column-major single-precision GEMM block.
// ----------------------------------------------------------------------------
package mmcm_pkg;

    localparam int MAX_DIM     = 8;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(MAX_DIM);
    localparam int DIM_W       = 4;
    localparam int IDX_W       = 6;
    localparam int CFG_IDX_W   = 2;

    localparam logic [1:0] ACT_LOAD_A = 2'd0;
    localparam logic [1:0] ACT_LOAD_B = 2'd1;
    localparam logic [1:0] ACT_START  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B     = 2'd2;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [IDX_W-1:0] element_index;
        logic [31:0]      element_value;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] result_index;
        logic [31:0]      result_value;
        logic             last_result;
    } out_item_t;

endpackage

[hdl/mmcm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmcm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mmcm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/mmcm_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmcm_mac
// Six-stage float32 multiply then add (acc + a*b), each op rounded to
// nearest even, NaNs canonical. Three stages per operation.
// ----------------------------------------------------------------------------
module mmcm_mac
    import mmcm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        go,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] acc,
    output logic        done,
    output logic [31:0] result
);

    function automatic logic [5:0] lzc50(input logic [49:0] v);
        logic [5:0] lz;
        lz = 6'd50;
        for (int i = 0; i < 50; i++) begin
            if (v[i]) lz = 6'(49 - i);
        end
        return lz;
    endfunction

    // m has its leading one at bit 47 (or less for tiny values); top 24 bits
    // are the significand at exponent e.
    function automatic logic [31:0] round_pack(input logic sgn,
                                               input logic signed [11:0] e,
                                               input logic [47:0] m);
        logic [47:0]        mm;
        logic signed [11:0] ee;
        logic [11:0]        sh;
        logic               st;
        logic               up;
        logic [24:0]        r;
        logic [7:0]         ef;
        mm = m;
        ee = e;
        if (ee < 12'sd1) begin
            sh = 12'(12'sd1 - ee);
            if (sh >= 12'd48) begin
                st = |mm;
                mm = {47'b0, st};
            end else begin
                st = |(mm & ((48'd1 << sh) - 48'd1));
                mm = (mm >> sh) | {47'b0, st};
            end
            ee = 12'sd1;
        end
        up = mm[23] & ((|mm[22:0]) | mm[24]);
        r  = {1'b0, mm[47:24]} + {24'b0, up};
        if (r[24]) begin
            r  = r >> 1;
            ee = ee + 12'sd1;
        end
        if (ee >= 12'sd255) begin
            return {sgn, 8'hFF, 23'b0};
        end
        ef = r[23] ? ee[7:0] : 8'd0;
        return {sgn, ef, r[22:0]};
    endfunction

    logic [5:0] vld_reg;

    // stage 1: multiply
    logic               m1_sgn_reg;
    logic [47:0]        m1_prod_reg;
    logic signed [11:0] m1_exp_reg;
    logic               m1_spec_reg;
    logic [31:0]        m1_val_reg;
    // stage 2: normalize product
    logic               m2_sgn_reg;
    logic [47:0]        m2_m_reg;
    logic signed [11:0] m2_exp_reg;
    logic               m2_spec_reg;
    logic [31:0]        m2_val_reg;
    // stage 3: rounded product
    logic [31:0]        prod_reg;
    // stage 4: align and add
    logic               a4_sgn_reg;
    logic [49:0]        a4_sum_reg;
    logic signed [11:0] a4_exp_reg;
    logic               a4_spec_reg;
    logic [31:0]        a4_val_reg;
    // stage 5: normalize sum
    logic               a5_sgn_reg;
    logic [47:0]        a5_m_reg;
    logic signed [11:0] a5_exp_reg;
    logic               a5_spec_reg;
    logic [31:0]        a5_val_reg;
    logic [31:0]        res_reg;

    // ---- multiply unpack ----
    logic        ma_nan, mb_nan, ma_inf, mb_inf, ma_zero, mb_zero, m_sgn;
    logic [23:0] ma, mb;
    logic [7:0]  mea, meb;
    logic        m_spec;
    logic [31:0] m_val;

    always_comb begin
        ma_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        mb_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        ma_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        mb_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        ma_zero = (a[30:0] == 31'd0);
        mb_zero = (b[30:0] == 31'd0);
        m_sgn   = a[31] ^ b[31];
        ma      = {a[30:23] != 8'd0, a[22:0]};
        mb      = {b[30:23] != 8'd0, b[22:0]};
        mea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        meb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        m_spec  = 1'b1;
        priority if (ma_nan || mb_nan || (ma_inf && mb_zero) || (ma_zero && mb_inf)) begin
            m_val = CANON_NAN;
        end else if (ma_inf || mb_inf) begin
            m_val = {m_sgn, 8'hFF, 23'b0};
        end else if (ma_zero || mb_zero) begin
            m_val = {m_sgn, 31'b0};
        end else begin
            m_val  = 32'd0;
            m_spec = 1'b0;
        end
    end

    // ---- add unpack (acc + prod_reg) ----
    logic        x_nan, y_nan, x_inf, y_inf, x_zero, y_zero;
    logic [31:0] big, sml;
    logic [7:0]  eb_big, eb_sml, dexp;
    logic [23:0] mbig, msml;
    logic [49:0] sml_full, sml_al, sum;
    logic        a_spec;
    logic [31:0] a_val;

    always_comb begin
        x_nan  = (acc[30:23] == 8'hFF) && (acc[22:0] != 23'd0);
        y_nan  = (prod_reg[30:23] == 8'hFF) && (prod_reg[22:0] != 23'd0);
        x_inf  = (acc[30:23] == 8'hFF) && (acc[22:0] == 23'd0);
        y_inf  = (prod_reg[30:23] == 8'hFF) && (prod_reg[22:0] == 23'd0);
        x_zero = (acc[30:0] == 31'd0);
        y_zero = (prod_reg[30:0] == 31'd0);
        // magnitude order follows the encoding order
        if (acc[30:0] >= prod_reg[30:0]) begin
            big = acc;
            sml = prod_reg;
        end else begin
            big = prod_reg;
            sml = acc;
        end
        eb_big   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        eb_sml   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        mbig     = {big[30:23] != 8'd0, big[22:0]};
        msml     = {sml[30:23] != 8'd0, sml[22:0]};
        dexp     = eb_big - eb_sml;
        sml_full = {1'b0, msml, 25'b0};
        if (dexp >= 8'd50) begin
            sml_al = {49'b0, |msml};
        end else begin
            sml_al = (sml_full >> dexp)
                   | {49'b0, |(sml_full & ((50'd1 << dexp) - 50'd1))};
        end
        if (big[31] == sml[31]) begin
            sum = {1'b0, mbig, 25'b0} + sml_al;
        end else begin
            sum = {1'b0, mbig, 25'b0} - sml_al;
        end
        a_spec = 1'b1;
        priority if (x_nan || y_nan || (x_inf && y_inf && (acc[31] != prod_reg[31]))) begin
            a_val = CANON_NAN;
        end else if (x_inf) begin
            a_val = acc;
        end else if (y_inf) begin
            a_val = prod_reg;
        end else if (x_zero && y_zero) begin
            a_val = {acc[31] & prod_reg[31], 31'b0};
        end else if (x_zero) begin
            a_val = prod_reg;
        end else if (y_zero) begin
            a_val = acc;
        end else begin
            a_val  = 32'd0;
            a_spec = 1'b0;
        end
    end

    logic [5:0]  p_lz, s_lz;
    logic [49:0] s_norm;

    always_comb begin
        p_lz   = lzc50({m1_prod_reg, 2'b0});
        s_lz   = lzc50(a4_sum_reg);
        s_norm = a4_sum_reg << s_lz;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[4:0], go};
        end
    end

    always_ff @(posedge aclk) begin
        m1_sgn_reg  <= m_sgn;
        m1_prod_reg <= ma * mb;
        m1_exp_reg  <= 12'(mea) + 12'(meb);
        m1_spec_reg <= m_spec;
        m1_val_reg  <= m_val;

        m2_sgn_reg  <= m1_sgn_reg;
        m2_m_reg    <= m1_prod_reg << p_lz;
        m2_exp_reg  <= m1_exp_reg - 12'sd126 - $signed(12'(p_lz));
        m2_spec_reg <= m1_spec_reg;
        m2_val_reg  <= m1_val_reg;

        prod_reg <= m2_spec_reg ? m2_val_reg : round_pack(m2_sgn_reg, m2_exp_reg, m2_m_reg);

        a4_sgn_reg  <= big[31];
        a4_sum_reg  <= sum;
        a4_exp_reg  <= $signed(12'(eb_big));
        a4_spec_reg <= a_spec;
        a4_val_reg  <= a_val;

        // exact cancellation gives +0
        a5_sgn_reg  <= a4_sgn_reg;
        a5_m_reg    <= {s_norm[49:3], |s_norm[2:0]};
        a5_exp_reg  <= a4_exp_reg + 12'sd1 - $signed(12'(s_lz));
        a5_spec_reg <= a4_spec_reg || (a4_sum_reg == 50'd0);
        a5_val_reg  <= a4_spec_reg ? a4_val_reg : 32'd0;

        res_reg <= a5_spec_reg ? a5_val_reg : round_pack(a5_sgn_reg, a5_exp_reg, a5_m_reg);
    end

    assign done   = vld_reg[5];
    assign result = res_reg;

endmodule

[hdl/matrix_multiply_column_major.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_column_major
// Column-major float32 C = A*B with load/start transactions.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel writes rows_a (0), inner_size (1), cols_b (2); always ready.
//   s channel: load A / load B transactions write one element into the A or
//   B RAM. A start transaction runs the multiply.
//   m channel: one transaction per element of C in column-major order, the
//   final one flagged by last_result.
//   Each multiply-add passes the RAM read, a wait, the 3-stage multiply
//   and the 3-stage add, and each element of C ends with an emit step.
//   s_ready is high only while no run is in progress; loads are taken while
//   the last result still waits on m_ready.
//   When m_ready is low the run stalls on the pending result.
//   Reset clears the control state and sets the sizes to 4; the A and B
//   RAMs keep whatever they held and must be loaded before use.
// ----------------------------------------------------------------------------
module matrix_multiply_column_major
    import mmcm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        if (v == '0) return DIM_W'(1);
        if (v > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
        return v;
    endfunction

    logic [DIM_W-1:0] rows_a_reg, inner_reg, cols_b_reg;
    logic [DIM_W-1:0] nr_reg, nr_next, ni_reg, ni_next, nc_reg, nc_next;
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] row_reg, row_next, col_reg, col_next, t_reg, t_next;
    logic [ADDR_W-1:0] a_addr_reg, a_addr_next, b_addr_reg, b_addr_next;
    logic [ADDR_W-1:0] b_base_reg, b_base_next;
    logic [IDX_W-1:0] c_reg, c_next;
    logic [31:0]      acc_reg, acc_next;
    logic             go_reg, go_next;
    out_item_t        out_reg, out_next;
    logic             m_valid_reg, m_valid_next;

    logic             s_fire, out_fire, last_row, last_col, last_t;
    logic             a_we, b_we, idx_ok;
    logic [31:0]      a_rdata, b_rdata, mac_result;
    logic             mac_done;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    assign idx_ok = {1'b0, s_data.element_index} < (IDX_W + 1)'(STORE_DEPTH);
    assign a_we   = s_fire && (s_data.action == ACT_LOAD_A) && idx_ok;
    assign b_we   = s_fire && (s_data.action == ACT_LOAD_B) && idx_ok;

    mmcm_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_a_ram (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (s_data.element_index[ADDR_W-1:0]),
        .wdata (s_data.element_value),
        .raddr (a_addr_reg),
        .rdata (a_rdata)
    );

    mmcm_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_b_ram (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (s_data.element_index[ADDR_W-1:0]),
        .wdata (s_data.element_value),
        .raddr (b_addr_reg),
        .rdata (b_rdata)
    );

    mmcm_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (go_reg),
        .a       (a_rdata),
        .b       (b_rdata),
        .acc     (acc_reg),
        .done    (mac_done),
        .result  (mac_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_a_reg <= DIM_W'(4);
            inner_reg  <= DIM_W'(4);
            cols_b_reg <= DIM_W'(4);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ROWS_A:     rows_a_reg <= cfg_data;
                CFG_INNER_SIZE: inner_reg  <= cfg_data;
                CFG_COLS_B:     cols_b_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            go_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            go_reg      <= go_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        nr_reg     <= nr_next;
        ni_reg     <= ni_next;
        nc_reg     <= nc_next;
        row_reg    <= row_next;
        col_reg    <= col_next;
        t_reg      <= t_next;
        a_addr_reg <= a_addr_next;
        b_addr_reg <= b_addr_next;
        b_base_reg <= b_base_next;
        c_reg      <= c_next;
        acc_reg    <= acc_next;
        out_reg    <= out_next;
    end

    assign last_row = (DIM_W'(row_reg) == nr_reg - DIM_W'(1));
    assign last_col = (DIM_W'(col_reg) == nc_reg - DIM_W'(1));
    assign last_t   = (DIM_W'(t_reg) == ni_reg - DIM_W'(1));
    assign out_fire = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        nr_next      = nr_reg;
        ni_next      = ni_reg;
        nc_next      = nc_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        t_next       = t_reg;
        a_addr_next  = a_addr_reg;
        b_addr_next  = b_addr_reg;
        b_base_next  = b_base_reg;
        c_next       = c_reg;
        acc_next     = acc_reg;
        go_next      = 1'b0;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_data.action == ACT_START)) begin
                    nr_next     = clamp_dim(rows_a_reg);
                    ni_next     = clamp_dim(inner_reg);
                    nc_next     = clamp_dim(cols_b_reg);
                    row_next    = '0;
                    col_next    = '0;
                    t_next      = '0;
                    a_addr_next = '0;
                    b_addr_next = '0;
                    b_base_next = '0;
                    c_next      = '0;
                    acc_next    = 32'd0;
                    state_next  = ST_READ;
                end
            end
            ST_READ: begin
                go_next    = 1'b1;
                state_next = ST_MAC;
            end
            ST_MAC: begin
                if (mac_done) begin
                    acc_next = mac_result;
                    if (last_t) begin
                        state_next = ST_EMIT;
                    end else begin
                        t_next      = t_reg + CNT_W'(1);
                        a_addr_next = a_addr_reg + ADDR_W'(nr_reg);
                        b_addr_next = b_addr_reg + ADDR_W'(1);
                        state_next  = ST_READ;
                    end
                end
            end
            ST_EMIT: begin
                if (out_fire) begin
                    m_valid_next          = 1'b1;
                    out_next.result_index = c_reg;
                    out_next.result_value = acc_reg;
                    out_next.last_result  = last_row && last_col;
                    if (last_row && last_col) begin
                        state_next = ST_IDLE;
                    end else begin
                        c_next   = c_reg + IDX_W'(1);
                        t_next   = '0;
                        acc_next = 32'd0;
                        if (last_row) begin
                            row_next    = '0;
                            col_next    = col_reg + CNT_W'(1);
                            b_base_next = b_base_reg + ADDR_W'(ni_reg);
                        end else begin
                            row_next = row_reg + CNT_W'(1);
                        end
                        a_addr_next = ADDR_W'(row_next);
                        b_addr_next = b_base_next;
                        state_next  = ST_READ;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_done_in_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_done |-> state_reg == ST_MAC)
        else $error("multiply-add finished outside ST_MAC");

    a_go_to_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        go_reg |-> state_reg == ST_MAC)
        else $error("multiply-add launched outside ST_MAC");

    a_t_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |-> DIM_W'(t_reg) < ni_reg)
        else $error("inner counter beyond inner size");

    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_fire && last_row && last_col) |=> state_reg == ST_IDLE && m_data.last_result)
        else $error("final result did not end the run");
`endif

endmodule

[bench/gemm_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gemm_result_checker
// Watches the config, load and result channels of the column-major GEMM
// block, keeps its own copy of the A/B stores and sizes, predicts every
// element of C at each start and compares results field by field in order.
// ----------------------------------------------------------------------------
module gemm_result_checker
    import mmcm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  in_item_t             s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  out_item_t            m_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   pending
);

    logic [31:0]      a_mem [STORE_DEPTH];
    logic [31:0]      b_mem [STORE_DEPTH];
    logic [DIM_W-1:0] rows_reg, inner_reg, cols_reg;
    out_item_t        c_expected_q [$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic int clamp_dim(logic [DIM_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    // single-precision bits -> double, subnormals normalized
    function automatic real float_to_real(logic [31:0] f);
        logic [63:0] d;
        logic [23:0] m;
        int          ex;
        d  = {f[31], 63'd0};
        m  = {1'b0, f[22:0]};
        ex = int'(f[30:23]);
        if (ex == 255) begin
            d[62:0] = {11'h7FF, f[22:0], 29'd0};
        end else if (ex != 0 || m != 0) begin
            if (ex == 0) begin
                ex = 1;
                while (!m[23]) begin
                    m  = m << 1;
                    ex = ex - 1;
                end
            end
            d[62:0] = {11'(ex + 896), m[22:0], 29'd0};
        end
        return $bitstoreal(d);
    endfunction

    // double -> single-precision bits, round to nearest even.
    // A double result of one float op rounds innocuously twice (53 >= 2*24+2).
    function automatic logic [31:0] real_to_float(real r);
        logic [63:0] d, sig, rest, half;
        logic [24:0] mant;
        logic        s;
        int          fe, sh;
        d = $realtobits(r);
        s = d[63];
        if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? CANON_NAN : {s, 8'hFF, 23'd0};
        if (d[62:52] == 0) return {s, 31'd0};
        fe  = int'(d[62:52]) - 896;
        sig = {11'd0, 1'b1, d[51:0]};
        sh  = (fe >= 1) ? 29 : 30 - fe;
        if (sh > 60) sh = 60;
        rest = sig & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        mant = 25'(sig >> sh);
        if (rest > half || (rest == half && mant[0])) mant = mant + 1;
        // subnormal; a carry into bit 23 lands on the smallest normal
        if (fe < 1) return {s, 6'd0, mant};
        if (mant[24]) begin
            mant = mant >> 1;
            fe   = fe + 1;
        end
        if (fe >= 255) return {s, 8'hFF, 23'd0};
        return {s, 8'(fe), mant[22:0]};
    endfunction

    function automatic logic [31:0] dot_elem(int row, int col, int nr, int ni);
        logic [31:0] acc, prod;
        acc = 32'd0;
        for (int t = 0; t < ni; t++) begin
            prod = real_to_float(float_to_real(a_mem[row + nr * t]) *
                                 float_to_real(b_mem[t + ni * col]));
            acc  = real_to_float(float_to_real(acc) + float_to_real(prod));
        end
        return acc;
    endfunction

    always @(posedge aclk) begin
        int        nr, ni, nc;
        out_item_t exp_item;
        if (!aresetn) begin
            rows_reg  <= 4'd4;
            inner_reg <= 4'd4;
            cols_reg  <= 4'd4;
            c_expected_q.delete();
            pending   <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ROWS_A:     rows_reg  <= cfg_data;
                    CFG_INNER_SIZE: inner_reg <= cfg_data;
                    CFG_COLS_B:     cols_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                case (s_data.action)
                    ACT_LOAD_A: a_mem[s_data.element_index] = s_data.element_value;
                    ACT_LOAD_B: b_mem[s_data.element_index] = s_data.element_value;
                    ACT_START: begin
                        nr = clamp_dim(rows_reg);
                        ni = clamp_dim(inner_reg);
                        nc = clamp_dim(cols_reg);
                        for (int c = 0; c < nr * nc; c++) begin
                            exp_item.result_index = IDX_W'(c);
                            exp_item.result_value = dot_elem(c % nr, c / nr, nr, ni);
                            exp_item.last_result  = (c + 1 == nr * nc);
                            c_expected_q.push_back(exp_item);
                        end
                    end
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (c_expected_q.size() == 0) begin
                    $display("%0t: unexpected result transaction idx=%0d val=%h last=%b",
                             $time, m_data.result_index, m_data.result_value,
                             m_data.last_result);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_item = c_expected_q.pop_front();
                    if (exp_item !== m_data) begin
                        if (exp_item.result_index !== m_data.result_index)
                            $display("%0t: result_index expected %0d got %0d", $time,
                                     exp_item.result_index, m_data.result_index);
                        if (exp_item.result_value !== m_data.result_value)
                            $display("%0t: result_value @%0d expected %h got %h", $time,
                                     exp_item.result_index, exp_item.result_value,
                                     m_data.result_value);
                        if (exp_item.last_result !== m_data.last_result)
                            $display("%0t: last_result @%0d expected %b got %b", $time,
                                     exp_item.result_index, exp_item.last_result,
                                     m_data.last_result);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= c_expected_q.size();
        end
    end

endmodule

[bench/tb_matrix_multiply_column_major.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_multiply_column_major
// Stimulus for the column-major GEMM block: directed float corner cases on
// 1x1x1 products and zero and clamped sizes, then random size settings
// with random loads, noise transactions, starts, gaps and result back-pressure.
// ----------------------------------------------------------------------------
module tb_matrix_multiply_column_major;
    import mmcm_pkg::*;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data  = '0;
    int                   fail_count, pending;

    logic                 a_loaded [STORE_DEPTH];
    logic                 b_loaded [STORE_DEPTH];
    int                   nr = 4, ni = 4, nc = 4;
    int                   item_count = 0, load_count = 0, start_count = 0;
    int                   elem_count = 0;
    int                   stall_left = 0, free_left = 0;
    int unsigned          roll;

    always #5 aclk = ~aclk;

    matrix_multiply_column_major uut (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_data,
        .m_valid, .m_ready, .m_data,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    gemm_result_checker chk (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_data,
        .m_valid, .m_ready, .m_data,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .fail_count, .pending
    );

    // result back-pressure: mostly random, with long stalls and free stretches
    always @(posedge aclk) begin
        roll = $urandom_range(0, 99);
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (free_left > 0) begin
            free_left <= free_left - 1;
            m_ready   <= 1'b1;
        end else if (roll < 3) begin
            free_left <= $urandom_range(50, 200);
            m_ready   <= 1'b1;
        end else if (roll < 6) begin
            stall_left <= $urandom_range(20, 60);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= (roll < 70);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_float();
        logic s;
        s = $urandom_range(0, 1);
        case ($urandom_range(0, 15))
            0: return {s, 31'd0};
            1: return {s, 8'hFF, 23'd0};
            2: return {s, 8'hFF, 23'($urandom) | 23'd1};
            3: return {s, 8'h00, 23'($urandom)};
            4: return {s, 31'h7F7F_FFFF};
            5: return {s, 8'($urandom_range(1, 3)), 23'($urandom)};
            6: return {s, 8'($urandom_range(250, 254)), 23'($urandom)};
            7: return $urandom;
            default: return {s, 8'($urandom_range(120, 134)), 23'($urandom)};
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 19))
            0: return 4'd0;
            1: return 4'd15;
            2: return 4'd8;
            3: return 4'd4;
            default: return DIM_W'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic int clamp_dim(logic [DIM_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    task automatic send(logic [1:0] act, logic [IDX_W-1:0] idx, logic [31:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{action: act, element_index: idx, element_value: val};
        do @(posedge aclk); while (!s_ready);
        if (act == ACT_LOAD_A) a_loaded[idx] = 1'b1;
        if (act == ACT_LOAD_B) b_loaded[idx] = 1'b1;
        if (act == ACT_LOAD_A || act == ACT_LOAD_B) load_count++;
        if (act == ACT_START) begin
            start_count++;
            elem_count += nr * nc;
        end
        if (act != 2'd3) item_count++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_sizes(logic [DIM_W-1:0] r, logic [DIM_W-1:0] k,
                             logic [DIM_W-1:0] c);
        wait_idle();
        write_reg(CFG_ROWS_A, r);
        write_reg(CFG_INNER_SIZE, k);
        write_reg(CFG_COLS_B, c);
        cfg_valid <= 1'b0;
        nr = clamp_dim(r);
        ni = clamp_dim(k);
        nc = clamp_dim(c);
    endtask

    // never let a start read an element that was not loaded
    task automatic fill_and_start();
        for (int i = 0; i < nr * ni; i++)
            if (!a_loaded[i]) send(ACT_LOAD_A, IDX_W'(i), pick_float());
        for (int i = 0; i < ni * nc; i++)
            if (!b_loaded[i]) send(ACT_LOAD_B, IDX_W'(i), pick_float());
        send(ACT_START, IDX_W'($urandom), $urandom);
    endtask

    task automatic one_product(logic [31:0] a, logic [31:0] b);
        send(ACT_LOAD_A, '0, a);
        send(ACT_LOAD_B, '0, b);
        send(ACT_START, '0, '0);
    endtask

    initial begin
        #200ms;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int nloads;
        logic [1:0] act;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            a_loaded[i] = 1'b0;
            b_loaded[i] = 1'b0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed float corners on 1x1x1
        set_sizes(4'd1, 4'd1, 4'd1);
        one_product(32'h3F80_0000, 32'h4000_0000);   // 1 * 2
        one_product(32'h7F80_0000, 32'h0000_0000);   // inf * 0 -> NaN
        one_product(32'h7F7F_FFFF, 32'h4000_0000);   // overflow to inf
        one_product(32'h0000_0001, 32'h3F00_0000);   // tie, rounds to even 0
        one_product(32'h8000_0000, 32'hBF80_0000);   // signed zero product
        one_product(32'h7FA0_0000, 32'h3F80_0000);   // signaling NaN in
        one_product(32'h0080_0000, 32'h3F00_0000);   // normal -> subnormal
        send(2'd3, IDX_W'($urandom), $urandom);      // unused action
        set_sizes(4'd0, 4'd0, 4'd0);                 // zero sizes act as 1
        fill_and_start();
        set_sizes(4'd15, 4'd1, 4'd15);               // clamps to 8x1x8
        fill_and_start();

        while (item_count < 270) begin
            if ($urandom_range(0, 2) != 0)
                set_sizes(pick_dim(), pick_dim(), pick_dim());
            nloads = $urandom_range(0, 8);
            for (int i = 0; i < nloads; i++) begin
                act = $urandom_range(0, 1) ? ACT_LOAD_B : ACT_LOAD_A;
                if ($urandom_range(0, 3) == 0)
                    send(act, IDX_W'($urandom), pick_float());
                else if (act == ACT_LOAD_A)
                    send(act, IDX_W'($urandom_range(0, nr * ni - 1)), pick_float());
                else
                    send(act, IDX_W'($urandom_range(0, ni * nc - 1)), pick_float());
            end
            if ($urandom_range(0, 9) == 0) send(2'd3, IDX_W'($urandom), $urandom);
            fill_and_start();
        end

        wait_idle();
        repeat (20) @(posedge aclk);
        $display("Covered %0d loads and %0d multiplies, %0d C elements predicted,",
                 load_count, start_count, elem_count);
        $display("with sizes from 1 to 8 including clamped 0 and 15 settings.");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
